// ===== hw/rtl/sxpk_pkg.sv =====
// Shared types and constants for the sysex 7-bit packing USB MIDI packetizer.
package sxpk_pkg;

  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_END   = 8'hF7;

  localparam int SXPK_GROUP_SIZE  = 7;
  localparam int SXPK_QUEUE_DEPTH = 4;

  // Item operations.
  localparam logic [1:0] OP_RAW = 2'd0;
  localparam logic [1:0] OP_PAY = 2'd1;
  localparam logic [1:0] OP_FIN = 2'd2;

  // USB MIDI code index numbers for sysex.
  localparam logic [2:0] CIN_CONT = 3'd4;
  localparam logic [2:0] CIN_END1 = 3'd5;
  localparam logic [2:0] CIN_END2 = 3'd6;
  localparam logic [2:0] CIN_END3 = 3'd7;

  // One byte bound for the packer, with what is left of its item behind it.
  typedef struct packed {
    logic       fin;   // item closes with a 0xF7 byte
    logic [3:0] rem;   // bytes of the same item still to follow
    logic [7:0] data;
  } sxpk_ent_t;

  localparam int SXPK_ENT_W = $bits(sxpk_ent_t);

  typedef enum logic {
    FE_IDLE,
    FE_FLUSH
  } sxpk_fe_state_t;

endpackage

// ===== hw/rtl/sxpk_queue.sv =====
// Small FIFO between the item front end and the packer.
module sxpk_queue import sxpk_pkg::*; #(
  parameter int DEPTH = SXPK_QUEUE_DEPTH,
  parameter int WIDTH = SXPK_ENT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/sxpk_front.sv =====
// Front end: takes items, gathers payload groups and feeds bytes to the queue.
module sxpk_front import sxpk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  output logic      q_push,
  input  logic      q_ready,
  output sxpk_ent_t q_ent
);

  sxpk_fe_state_t st_r, st_nxt;

  logic [2:0] grp_cnt_r, grp_cnt_nxt;
  logic [6:0] grp_top_r, grp_top_nxt;
  logic [6:0] low_r [SXPK_GROUP_SIZE];

  logic [6:0] fl_top_r, fl_top_nxt;
  logic [2:0] fl_n_r, fl_n_nxt;
  logic       fl_fin_r, fl_fin_nxt;
  logic [3:0] fl_idx_r, fl_idx_nxt;

  logic       accept;
  logic [6:0] top_new;
  logic [3:0] fl_rem;
  logic [2:0] low_sel;
  logic       grp_full;

  assign in_ready = (st_r == FE_IDLE) && q_ready;
  assign accept   = in_valid && in_ready;
  assign top_new  = grp_top_r | (7'(in_data_byte[7]) << grp_cnt_r);
  assign grp_full = (grp_cnt_r == 3'(SXPK_GROUP_SIZE - 1));
  assign fl_rem   = {1'b0, fl_n_r} + {3'b0, fl_fin_r} - fl_idx_r;
  assign low_sel  = fl_idx_r[2:0] - 3'd1;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FE_IDLE: begin
        if (accept && ((in_op == OP_PAY && grp_full) ||
                       (in_op == OP_FIN && grp_cnt_r != 3'd0))) begin
          st_nxt = FE_FLUSH;
        end
      end
      FE_FLUSH: begin
        if (q_ready && fl_rem == 4'd0) begin
          st_nxt = FE_IDLE;
        end
      end
      default: st_nxt = FE_IDLE;
    endcase
  end

  // outputs: queue word
  always_comb begin
    q_push = 1'b0;
    q_ent  = '{fin: 1'b0, rem: 4'd0, data: in_data_byte};
    case (st_r)
      FE_IDLE: begin
        if (in_valid && in_op == OP_RAW) begin
          q_push = 1'b1;
        end else if (in_valid && in_op == OP_FIN && grp_cnt_r == 3'd0) begin
          q_push     = 1'b1;
          q_ent.data = SYX_END;
        end
      end
      FE_FLUSH: begin
        q_push    = 1'b1;
        q_ent.fin = fl_fin_r;
        q_ent.rem = fl_rem;
        if (fl_idx_r == 4'd0) begin
          q_ent.data = {1'b0, fl_top_r};
        end else if (fl_idx_r <= {1'b0, fl_n_r}) begin
          q_ent.data = {1'b0, low_r[low_sel]};
        end else begin
          q_ent.data = SYX_END;
        end
      end
      default: q_push = 1'b0;
    endcase
  end

  // group and flush bookkeeping
  always_comb begin
    grp_cnt_nxt = grp_cnt_r;
    grp_top_nxt = grp_top_r;
    fl_top_nxt  = fl_top_r;
    fl_n_nxt    = fl_n_r;
    fl_fin_nxt  = fl_fin_r;
    fl_idx_nxt  = fl_idx_r;
    if (accept && in_op == OP_PAY) begin
      if (grp_full) begin
        fl_top_nxt  = top_new;
        fl_n_nxt    = 3'(SXPK_GROUP_SIZE);
        fl_fin_nxt  = 1'b0;
        fl_idx_nxt  = 4'd0;
        grp_cnt_nxt = 3'd0;
        grp_top_nxt = 7'd0;
      end else begin
        grp_cnt_nxt = grp_cnt_r + 3'd1;
        grp_top_nxt = top_new;
      end
    end else if (accept && in_op == OP_FIN && grp_cnt_r != 3'd0) begin
      fl_top_nxt  = grp_top_r;
      fl_n_nxt    = grp_cnt_r;
      fl_fin_nxt  = 1'b1;
      fl_idx_nxt  = 4'd0;
      grp_cnt_nxt = 3'd0;
      grp_top_nxt = 7'd0;
    end else if (st_r == FE_FLUSH && q_ready) begin
      fl_idx_nxt = fl_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= FE_IDLE;
      grp_cnt_r <= 3'd0;
      grp_top_r <= 7'd0;
    end else begin
      st_r      <= st_nxt;
      grp_cnt_r <= grp_cnt_nxt;
      grp_top_r <= grp_top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fl_top_r <= fl_top_nxt;
    fl_n_r   <= fl_n_nxt;
    fl_fin_r <= fl_fin_nxt;
    fl_idx_r <= fl_idx_nxt;
    if (accept && in_op == OP_PAY) begin
      low_r[grp_cnt_r] <= in_data_byte[6:0];
    end
  end

  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == FE_FLUSH |-> !in_ready)
    else $error("item taken during group flush");

  a_group_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_cnt_r != 3'd7)
    else $error("group count reached a full group without flushing");

endmodule

// ===== hw/rtl/sxpk_back.sv =====
// Back end: packs queued bytes up to three to a USB MIDI packet and holds the output word.
module sxpk_back import sxpk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  sxpk_ent_t  q_ent,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_code_index,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic [7:0] out_third_byte,
  output logic       out_last_of_run
);

  logic [1:0]  fill_r, fill_nxt;
  logic [15:0] pb_r, pb_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  code_r, code_nxt;
  logic [7:0]  b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic        last_r, last_nxt;

  logic        is_start, is_end, emit, out_free, later;
  logic [1:0]  f0, f_after;
  logic [15:0] pb0;
  logic [7:0]  b0, b1, b2;
  logic [2:0]  code;
  logic [4:0]  reach;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    is_start = (q_ent.data == SYX_START);
    is_end   = (q_ent.data == SYX_END);
    f0       = is_start ? 2'd0 : fill_r;
    pb0      = is_start ? 16'd0 : pb_r;
    b0       = (f0 == 2'd0) ? q_ent.data : pb0[7:0];
    b1       = (f0 == 2'd1) ? q_ent.data : pb0[15:8];
    b2       = (f0 == 2'd2) ? q_ent.data : 8'd0;
    emit     = is_end || (f0 == 2'd2);
    case (f0)
      2'd0:    code = is_end ? CIN_END1 : CIN_CONT;
      2'd1:    code = is_end ? CIN_END2 : CIN_CONT;
      2'd2:    code = is_end ? CIN_END3 : CIN_CONT;
      default: code = CIN_CONT;
    endcase
    // later bytes of this item are plain 7-bit bytes, plus a closing 0xF7 on finish
    f_after = emit ? 2'd0 : f0 + 2'd1;
    reach   = {1'b0, q_ent.rem} + {3'b0, f_after};
    later   = (q_ent.fin && q_ent.rem != 4'd0) || (reach >= 5'd3);
    q_pop   = q_valid && (!emit || out_free);
  end

  always_comb begin
    fill_nxt      = fill_r;
    pb_nxt        = pb_r;
    out_valid_nxt = out_valid_r && !out_ready;
    code_nxt      = code_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    last_nxt      = last_r;
    if (q_pop) begin
      if (emit) begin
        fill_nxt      = 2'd0;
        pb_nxt        = 16'd0;
        out_valid_nxt = 1'b1;
        code_nxt      = code;
        b0_nxt        = b0;
        b1_nxt        = b1;
        b2_nxt        = b2;
        last_nxt      = !later;
      end else begin
        fill_nxt = f0 + 2'd1;
        pb_nxt   = {b1, b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 2'd0;
      pb_r        <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pb_r        <= pb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    b0_r   <= b0_nxt;
    b1_r   <= b1_nxt;
    b2_r   <= b2_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_index  = code_r;
  assign out_first_byte  = b0_r;
  assign out_second_byte = b1_r;
  assign out_third_byte  = b2_r;
  assign out_last_of_run = last_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("packet fill out of range");

  a_short_end_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && code_r == CIN_END1 |-> b1_r == 8'd0 && b2_r == 8'd0)
    else $error("single-byte end packet carries stray bytes");

endmodule

// ===== hw/rtl/sysex_7bit_pack_usb_midi_packetizer.sv =====
// Top level of the sysex 7-bit packing USB MIDI packetizer.
//
// Input channel (in_valid/in_ready, in_op, in_data_byte) takes one word per item:
// a raw sysex byte, a payload byte for 7-bit packing, or a finish. Output channel
// (out_valid/out_ready) carries one 4-byte USB MIDI event packet per word, with
// out_last_of_run marking the final packet caused by an item.
// The front end gathers payload bytes in groups of seven; a full group, or a
// finish, is flushed as a top-bits byte plus the low-7-bit bytes, one byte per
// cycle into a short queue while it has room. The back end packs one queued
// byte per cycle, holding a packet-closing byte while the output word is held.
// Throughput: raw and non-flushing payload items go at one per cycle while the
// queue has room. A flushing item holds the input until its top-bits byte, low
// bytes and, for a finish, closing 0xF7 are all queued. A byte that closes a
// packet passes through the queue, then the packer's output register.
// Reset (synchronous, rst_n low) empties the queue and the output register and
// clears the packet fill and group count.
// When the receiver stalls the output word holds; the packer stops on the next
// byte that would close a packet, the queue fills, and then in_ready drops.
module sysex_7bit_pack_usb_midi_packetizer import sxpk_pkg::*; #(
  parameter int QUEUE_DEPTH = SXPK_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_code_index,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic [7:0] out_third_byte,
  output logic       out_last_of_run
);

  logic      q_push, q_ready, q_valid, q_pop;
  sxpk_ent_t q_push_ent, q_pop_ent;

  sxpk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_push       (q_push),
    .q_ready      (q_ready),
    .q_ent        (q_push_ent)
  );

  sxpk_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SXPK_ENT_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_data  (q_push_ent),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_pop_ent)
  );

  sxpk_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_ent           (q_pop_ent),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_index  (out_code_index),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_third_byte  (out_third_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
